>>> sv/ppp_pkg.sv
package ppp_pkg;

  localparam int DEF_WIDTH  = 256;
  localparam int DEF_HEIGHT = 256;

  localparam logic [1:0] MODE_PROJECT = 2'd0;
  localparam logic [1:0] MODE_PICK    = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  localparam logic [31:0] MARK_COLOR = 32'h1496FAFF;

  localparam logic [2:0] REG_COS_PITCH = 3'd0;
  localparam logic [2:0] REG_SIN_PITCH = 3'd1;
  localparam logic [2:0] REG_COS_YAW   = 3'd2;
  localparam logic [2:0] REG_SIN_YAW   = 3'd3;
  localparam logic [2:0] REG_CAM_X     = 3'd4;
  localparam logic [2:0] REG_CAM_Y     = 3'd5;
  localparam logic [2:0] REG_CAM_Z     = 3'd6;
  localparam logic [2:0] REG_FOCAL     = 3'd7;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [31:0]        point_color;
    logic [15:0]        point_index;
    logic               marked;
    logic [7:0]         query_x;
    logic [7:0]         query_y;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] found_index;
    logic [31:0] pixel_color;
  } res_t;

  typedef struct packed {
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_pitch;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic [31:0]        focal_pair;
  } cfg_t;

  // Projection outcome handed from the geometry unit to the store sequencer.
  typedef struct packed {
    logic        hit;
    logic [12:0] col;
    logic [12:0] row;
  } proj_t;

endpackage

>>> sv/ppp_div.sv
// Restoring signed floor divider, one quotient bit per cycle.
module ppp_div
  import ppp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic [47:0]        den,
  output logic               done,
  output logic signed [63:0] quo
);
  logic [63:0] mag;
  logic [63:0] q;
  logic [48:0] rem;
  logic [6:0]  cnt;
  logic        neg;
  logic        run;
  logic [48:0] trial;

  assign trial = {rem[47:0], mag[63]} - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
      neg <= num[63];
      mag <= num[63] ? 64'(-num - 64'sd1) : num;
      rem <= '0;
      q   <= '0;
      cnt <= 7'd0;
    end else if (run) begin
      if (!trial[48]) begin
        rem <= trial;
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= {rem[47:0], mag[63]};
        q   <= {q[62:0], 1'b0};
      end
      mag <= {mag[62:0], 1'b0};
      cnt <= cnt + 7'd1;
      if (cnt == 7'd63) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // For negative numerators floor(n/d) = -((-n-1)/d) - 1.
  assign quo = neg ? 64'(-$signed(q) - 64'sd1) : $signed(q);
endmodule

>>> sv/ppp_geom.sv
// Camera transform with one shared multiplier, then two floor divisions.
module ppp_geom
  import ppp_pkg::*;
#(
  parameter int WIDTH  = DEF_WIDTH,
  parameter int HEIGHT = DEF_HEIGHT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cfg_t               cfg,
  input  logic signed [31:0] px,
  input  logic signed [31:0] py,
  input  logic signed [31:0] pz,
  output logic               done,
  output proj_t              proj
);
  localparam logic [3:0] G_IDLE = 4'd0, G_MUL = 4'd1, G_SUM = 4'd2,
                         G_DX = 4'd3, G_DIVY = 4'd5, G_DONE = 4'd6;

  logic [3:0]         state;
  logic [3:0]         step;
  logic signed [33:0] dx, dy, dz;
  logic signed [17:0] ss, sc, cs, cc;
  logic signed [63:0] ax, ay, az;
  logic signed [63:0] xs, ys, zs;
  logic signed [33:0] ma;
  logic signed [17:0] mb;
  logic signed [51:0] prod;
  logic signed [31:0] prod_rnd;
  logic               dstart;
  logic signed [63:0] dnum;
  logic [47:0]        dden;
  logic               ddone;
  logic signed [63:0] dquo;
  logic signed [63:0] col;

  ppp_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dquo)
  );

  assign prod     = ma * mb;
  assign prod_rnd = 32'((prod + 52'sd8192) >>> 14);

  // Operand schedule for the shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step)
      4'd0:  begin ma = 34'(cfg.sin_pitch); mb = 18'(cfg.sin_yaw); end
      4'd1:  begin ma = 34'(cfg.sin_pitch); mb = 18'(cfg.cos_yaw); end
      4'd2:  begin ma = 34'(cfg.cos_pitch); mb = 18'(cfg.sin_yaw); end
      4'd3:  begin ma = 34'(cfg.cos_pitch); mb = 18'(cfg.cos_yaw); end
      4'd4:  begin ma = dx; mb = 18'(cfg.cos_yaw); end
      4'd5:  begin ma = dz; mb = -18'(cfg.sin_yaw); end
      4'd6:  begin ma = dx; mb = -ss; end
      4'd7:  begin ma = dy; mb = 18'(cfg.cos_pitch); end
      4'd8:  begin ma = dz; mb = -sc; end
      4'd9:  begin ma = dx; mb = cs; end
      4'd10: begin ma = dy; mb = 18'(cfg.sin_pitch); end
      4'd11: begin ma = dz; mb = cc; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    dstart <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state <= G_IDLE;
    end else begin
      unique case (state)
        G_IDLE: if (start) begin
          dx <= 34'(px) - 34'(cfg.cam_x);
          dy <= -34'(pz) - 34'(cfg.cam_y);
          dz <= 34'(py) - 34'(cfg.cam_z);
          ax <= '0; ay <= '0; az <= '0;
          step  <= 4'd0;
          state <= G_MUL;
        end
        G_MUL: begin
          unique case (step)
            4'd0: ss <= 18'(prod_rnd);
            4'd1: sc <= 18'(prod_rnd);
            4'd2: cs <= 18'(prod_rnd);
            4'd3: cc <= 18'(prod_rnd);
            4'd4, 4'd5: ax <= ax + 64'(prod);
            4'd6, 4'd7, 4'd8: ay <= ay + 64'(prod);
            default: az <= az + 64'(prod);
          endcase
          step <= step + 4'd1;
          if (step == 4'd11) state <= G_SUM;
        end
        G_SUM: begin
          xs <= (ax + 64'sd8192) >>> 14;
          ys <= (ay + 64'sd8192) >>> 14;
          zs <= (az + 64'sd8192) >>> 14;
          state <= G_DX;
        end
        G_DX: begin
          if (zs <= 0) begin
            proj  <= '0;
            state <= G_DONE;
          end else begin
            dnum   <= 64'(xs * $signed({1'b0, cfg.focal_pair[31:16]}) * 2)
                      + 64'(zs * WIDTH);
            dden   <= 48'(zs <<< 1);
            dstart <= 1'b1;
            state  <= G_DIVY;
            step   <= 4'd0;
          end
        end
        G_DIVY: if (ddone) begin
          if (step == 4'd0) begin
            col    <= dquo;
            dnum   <= 64'(ys * $signed({1'b0, cfg.focal_pair[15:0]}) * 2)
                      + 64'(zs * HEIGHT);
            dstart <= 1'b1;
            step   <= 4'd1;
          end else begin
            proj.hit <= col >= 0 && col < WIDTH && dquo >= 0 && dquo < HEIGHT;
            proj.col <= 13'(col);
            proj.row <= 13'(dquo);
            state    <= G_DONE;
          end
        end
        G_DONE: begin
          done  <= 1'b1;
          state <= G_IDLE;
        end
        default: state <= G_IDLE;
      endcase
    end
  end
endmodule

>>> sv/point_projector_with_picking_top.sv
// Command-driven point projector. An item is taken when start is high and busy
// is low; its single result appears for one cycle on res with done high and
// cannot be stalled. A projection runs the camera transform on one shared
// multiplier, then two 64-step serial divisions, plus up to 25 marker writes;
// a pick makes one index-store read per window pixel; a read passes through
// S_READ and S_READW. Clear walks all WIDTH*HEIGHT entries of both stores one
// entry per cycle; the same sweep runs once after reset while busy.
module point_projector_with_picking_top
  import ppp_pkg::*;
#(
  parameter int WIDTH  = DEF_WIDTH,
  parameter int HEIGHT = DEF_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  cmd_t        cmd,
  output logic        busy,
  output logic        done,
  output res_t        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int CW   = $clog2(WIDTH);
  localparam int RW   = $clog2(HEIGHT);

  localparam logic [3:0] S_IDLE = 4'd0, S_GEOM = 4'd1, S_MARK = 4'd2,
                         S_PICK = 4'd3, S_PICKW = 4'd4, S_READ = 4'd5,
                         S_READW = 4'd6, S_CLEAR = 4'd7, S_OUT = 4'd8;

  cfg_t        cfg;
  logic [3:0]  state;
  cmd_t        item;
  res_t        r;
  logic [AW-1:0] sweep;
  logic        item_live;

  logic [31:0] frame_mem [NPIX];
  logic [16:0] index_mem [NPIX];
  logic        fwe, iwe;
  logic [AW-1:0] faddr, iaddr;
  logic [31:0] fwd;
  logic [16:0] iwd;
  logic [31:0] frd;
  logic [16:0] ird;

  logic        gstart, gdone;
  proj_t       proj;
  logic [12:0] wl, wr, wu, wd, ci, cj, cx, cy;
  logic        rd_pend;

  // Register file.
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_pitch  <= 16'sd16384;
      cfg.sin_pitch  <= '0;
      cfg.cos_yaw    <= 16'sd16384;
      cfg.sin_yaw    <= '0;
      cfg.cam_x      <= '0;
      cfg.cam_y      <= '0;
      cfg.cam_z      <= '0;
      cfg.focal_pair <= 32'h00800080;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[4:2])
        REG_COS_PITCH: cfg.cos_pitch  <= pwdata[15:0];
        REG_SIN_PITCH: cfg.sin_pitch  <= pwdata[15:0];
        REG_COS_YAW:   cfg.cos_yaw    <= pwdata[15:0];
        REG_SIN_YAW:   cfg.sin_yaw    <= pwdata[15:0];
        REG_CAM_X:     cfg.cam_x      <= pwdata;
        REG_CAM_Y:     cfg.cam_y      <= pwdata;
        REG_CAM_Z:     cfg.cam_z      <= pwdata;
        default:       cfg.focal_pair <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_COS_PITCH: prdata = 32'(cfg.cos_pitch);
      REG_SIN_PITCH: prdata = 32'(cfg.sin_pitch);
      REG_COS_YAW:   prdata = 32'(cfg.cos_yaw);
      REG_SIN_YAW:   prdata = 32'(cfg.sin_yaw);
      REG_CAM_X:     prdata = cfg.cam_x;
      REG_CAM_Y:     prdata = cfg.cam_y;
      REG_CAM_Z:     prdata = cfg.cam_z;
      default:       prdata = cfg.focal_pair;
    endcase
  end

  ppp_geom #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_geom (
    .clk(clk), .rst(rst), .start(gstart), .cfg(cfg),
    .px(item.point_x), .py(item.point_y), .pz(item.point_z),
    .done(gdone), .proj(proj)
  );

  // Single-port stores with registered read data.
  always_ff @(posedge clk) begin
    if (fwe) frame_mem[faddr] <= fwd;
    frd <= frame_mem[faddr];
  end
  always_ff @(posedge clk) begin
    if (iwe) index_mem[iaddr] <= iwd;
    ird <= index_mem[iaddr];
  end

  // Clipped 5x5 window around the point or the query. While idle the window
  // follows the incoming query so the walker starts on the right corner.
  always_comb begin
    cx = (state == S_GEOM || state == S_MARK) ? proj.col :
         (state == S_IDLE) ? 13'(cmd.query_x) : 13'(item.query_x);
    cy = (state == S_GEOM || state == S_MARK) ? proj.row :
         (state == S_IDLE) ? 13'(cmd.query_y) : 13'(item.query_y);
    wl = (cx < 13'd2) ? 13'd0 : cx - 13'd2;
    wr = (cx + 13'd2 > 13'(WIDTH - 1)) ? 13'(WIDTH - 1) : cx + 13'd2;
    wu = (cy < 13'd2) ? 13'd0 : cy - 13'd2;
    wd = (cy + 13'd2 > 13'(HEIGHT - 1)) ? 13'(HEIGHT - 1) : cy + 13'd2;
  end

  // Store port control.
  always_comb begin
    fwe = 1'b0; iwe = 1'b0;
    fwd = item.point_color;
    iwd = {1'b1, item.point_index};
    faddr = sweep;
    iaddr = sweep;
    unique case (state)
      S_CLEAR: begin
        fwe = 1'b1; iwe = 1'b1; fwd = '0; iwd = '0;
      end
      S_GEOM: if (gdone && proj.hit) begin
        fwe = 1'b1; iwe = 1'b1;
        faddr = AW'(proj.row * WIDTH + proj.col);
        iaddr = faddr;
      end
      S_MARK: begin
        fwe = 1'b1; fwd = MARK_COLOR;
        faddr = AW'(cj * WIDTH + ci);
      end
      S_PICK, S_PICKW: iaddr = AW'(cj * WIDTH + ci);
      S_READ, S_READW: faddr = AW'(item.query_y * WIDTH + item.query_x);
      default: ;
    endcase
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    gstart <= 1'b0;
    done   <= 1'b0;
    if (rst) begin
      state   <= S_CLEAR;
      sweep   <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (start) begin
          item  <= cmd;
          r     <= '0;
          sweep <= '0;
          unique case (cmd.mode)
            MODE_PROJECT: begin gstart <= 1'b1; state <= S_GEOM; end
            MODE_PICK: begin
              if (cmd.query_x < WIDTH && cmd.query_y < HEIGHT) state <= S_PICK;
              else state <= S_OUT;
              rd_pend <= 1'b0;
            end
            MODE_READ:
              if (cmd.query_x < WIDTH && cmd.query_y < HEIGHT) state <= S_READ;
              else state <= S_OUT;
            default: state <= S_CLEAR;
          endcase
        end
        S_GEOM: if (gdone) begin
          if (proj.hit) begin
            r.hit     <= 1'b1;
            r.pixel_x <= proj.col[7:0];
            r.pixel_y <= proj.row[7:0];
          end
          if (proj.hit && item.marked) begin
            state <= S_MARK;
          end else begin
            state <= S_OUT;
          end
        end
        S_MARK: begin
          if (cj == wd) begin
            if (ci == wr) state <= S_OUT;
          end
        end
        S_PICK: begin
          rd_pend <= 1'b1;
          if (rd_pend && ird[16]) begin
            r.hit <= 1'b1; r.found_index <= ird[15:0];
          end
          if (cj == wd && ci == wr) state <= S_PICKW;
        end
        S_PICKW: begin
          if (ird[16]) begin
            r.hit <= 1'b1; r.found_index <= ird[15:0];
          end
          state <= S_OUT;
        end
        S_READ: state <= S_READW;
        S_READW: begin
          r.hit <= 1'b1; r.pixel_color <= frd; state <= S_OUT;
        end
        S_CLEAR: begin
          sweep <= sweep + AW'(1);
          // The sweep after reset ends quietly; a clear item gets its result.
          if (sweep == AW'(NPIX - 1)) state <= item_live ? S_OUT : S_IDLE;
        end
        S_OUT: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Window walker, column-major like the scan order.
  always_ff @(posedge clk) begin
    if (state == S_IDLE || (state == S_GEOM)) begin
      ci <= wl; cj <= wu;
    end else if (state == S_MARK || state == S_PICK) begin
      if (cj == wd) begin
        cj <= wu; ci <= ci + 13'd1;
      end else begin
        cj <= cj + 13'd1;
      end
    end
  end

  // Reset sweep must not emit a result: only a taken item reaches S_OUT live.
  always_ff @(posedge clk) begin
    if (rst) item_live <= 1'b0;
    else if (state == S_IDLE && start) item_live <= 1'b1;
    else if (state == S_OUT) item_live <= 1'b0;
  end

  assign busy = (state != S_IDLE);
  assign res  = r;

`ifndef ASSERT_OFF
  a_done_after_out: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_OUT) else $error("result without output state");
  a_busy_on_take: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("item taken but not busy");
  a_no_mark_miss: assert property (@(posedge clk) disable iff (rst)
    state == S_MARK |-> r.hit) else $error("marker drawn for a missed point");
`endif
endmodule

>>> verif/point_projector_with_picking_top_test.sv
module point_projector_with_picking_top_test;
  import ppp_pkg::*;

  localparam int  W       = DEF_WIDTH;
  localparam int  H       = DEF_HEIGHT;
  localparam longint Q    = 65536;
  localparam int  LIMIT   = 3000000;
  localparam int  PHASES  = 6;
  localparam int  PER_PHASE = 190;
  localparam int  CMD_BITS  = $bits(cmd_t);

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = '0;
  logic        busy;
  logic        done;
  res_t        res;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  point_projector_with_picking_top uut (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .busy(busy), .done(done),
    .res(res), .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block: configuration and both stores.
  longint      cpitch, spitch, cyaw, syaw, camx, camy, camz;
  logic [31:0] focal;
  logic [31:0] frame_mirror [W*H];
  logic [16:0] index_mirror [W*H];

  res_t        results_due [$];
  int          errors = 0;
  int          cycles = 0;
  int          drawn = 0, picks_found = 0, reads = 0, clears = 0, items = 0;
  int          last_col = 128, last_row = 128;
  bit          idling = 1'b1;

  typedef struct {
    cmd_t c;
    bit   typed;
    res_t r;
  } row_t;
  row_t directed [$];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, results_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint round14(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic void wipe_stores();
    for (int i = 0; i < W*H; i++) begin
      frame_mirror[i] = '0;
      index_mirror[i] = '0;
    end
  endfunction

  // Computes the result of one item and applies its effect on the stores.
  function automatic res_t project_pick_read(cmd_t c);
    longint dx, dy, dz, ss, sc, cs, cc, x, y, z, xs, ys, zs, col, row;
    int l, r, u, d;
    res_t o;
    o = '0;
    case (c.mode)
      MODE_PROJECT: begin
        dx = longint'(c.point_x) - camx;
        dy = -longint'(c.point_z) - camy;
        dz = longint'(c.point_y) - camz;
        ss = round14(spitch * syaw);
        sc = round14(spitch * cyaw);
        cs = round14(cpitch * syaw);
        cc = round14(cpitch * cyaw);
        x = cyaw * dx - syaw * dz;
        y = -ss * dx + cpitch * dy - sc * dz;
        z = cs * dx + spitch * dy + cc * dz;
        xs = round14(x);
        ys = round14(y);
        zs = round14(z);
        if (zs > 0) begin
          col = floor_quot(2 * xs * longint'(focal[31:16]) + W * zs, 2 * zs);
          row = floor_quot(2 * ys * longint'(focal[15:0]) + H * zs, 2 * zs);
          if (col >= 0 && col < W && row >= 0 && row < H) begin
            frame_mirror[row*W+col] = c.point_color;
            index_mirror[row*W+col] = {1'b1, c.point_index};
            if (c.marked) begin
              l = (col < 2) ? 0 : int'(col) - 2;
              r = (col + 2 > W - 1) ? W - 1 : int'(col) + 2;
              u = (row < 2) ? 0 : int'(row) - 2;
              d = (row + 2 > H - 1) ? H - 1 : int'(row) + 2;
              for (int i = l; i <= r; i++)
                for (int j = u; j <= d; j++) frame_mirror[j*W+i] = MARK_COLOR;
            end
            o.hit = 1'b1;
            o.pixel_x = col[7:0];
            o.pixel_y = row[7:0];
            last_col = int'(col);
            last_row = int'(row);
            drawn++;
          end
        end
      end
      MODE_PICK: begin
        if (c.query_x < W && c.query_y < H) begin
          l = (c.query_x < 2) ? 0 : int'(c.query_x) - 2;
          r = (c.query_x + 2 > W - 1) ? W - 1 : int'(c.query_x) + 2;
          u = (c.query_y < 2) ? 0 : int'(c.query_y) - 2;
          d = (c.query_y + 2 > H - 1) ? H - 1 : int'(c.query_y) + 2;
          for (int i = l; i <= r; i++)
            for (int j = u; j <= d; j++)
              if (index_mirror[j*W+i][16]) begin
                o.hit = 1'b1;
                o.found_index = index_mirror[j*W+i][15:0];
              end
          if (o.hit) picks_found++;
        end
      end
      MODE_READ: begin
        if (c.query_x < W && c.query_y < H) begin
          o.hit = 1'b1;
          o.pixel_color = frame_mirror[c.query_y*W+c.query_x];
        end
        reads++;
      end
      default: begin
        wipe_stores();
        clears++;
      end
    endcase
    return o;
  endfunction

  // Result checker: the receiver never stalls, so each done cycle is a result.
  always @(negedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (results_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, res);
        errors++;
      end else begin
        e = results_due.pop_front();
        if (res.hit !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, res.hit);
          errors++;
        end
        if (res.pixel_x !== e.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, e.pixel_x, res.pixel_x);
          errors++;
        end
        if (res.pixel_y !== e.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, e.pixel_y, res.pixel_y);
          errors++;
        end
        if (res.found_index !== e.found_index) begin
          $display("%0t: found_index expected %h actual %h", $time, e.found_index,
                   res.found_index);
          errors++;
        end
        if (res.pixel_color !== e.pixel_color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, e.pixel_color,
                   res.pixel_color);
          errors++;
        end
      end
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic issue(cmd_t c, bit typed, res_t r);
    bit   taken;
    res_t p;
    start <= 1'b1;
    cmd <= c;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    p = project_pick_read(c);
    results_due.push_back(typed ? r : p);
    items++;
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // One register write: setup cycle, access cycle, then an idle cycle so
  // that back-to-back writes never drive the port twice in one step.
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_COS_PITCH: cpitch = longint'($signed(v[15:0]));
      REG_SIN_PITCH: spitch = longint'($signed(v[15:0]));
      REG_COS_YAW:   cyaw = longint'($signed(v[15:0]));
      REG_SIN_YAW:   syaw = longint'($signed(v[15:0]));
      REG_CAM_X:     camx = longint'($signed(v));
      REG_CAM_Y:     camy = longint'($signed(v));
      REG_CAM_Z:     camz = longint'($signed(v));
      default:       focal = v;
    endcase
  endtask

  // Lets every outstanding item finish before the registers change.
  task automatic wait_quiet();
    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic cmd_t mk(logic [1:0] m, longint x, longint y, longint z,
                              logic [31:0] color, logic [15:0] idx, bit mk_on,
                              logic [7:0] qx, logic [7:0] qy);
    cmd_t c;
    c.mode = m;
    c.point_x = x[31:0];
    c.point_y = y[31:0];
    c.point_z = z[31:0];
    c.point_color = color;
    c.point_index = idx;
    c.marked = mk_on;
    c.query_x = qx;
    c.query_y = qy;
    return c;
  endfunction

  function automatic void add(cmd_t c, bit typed, res_t r);
    row_t e;
    e.c = c;
    e.typed = typed;
    e.r = r;
    directed.push_back(e);
  endfunction

  function automatic logic [15:0] q14(real v);
    return 16'($rtoi(v * 16384.0));
  endfunction

  task automatic set_phase(int k);
    real pitch, yaw;
    case (k)
      0, 2: begin
        write_reg(REG_COS_PITCH, 32'(16384));
        write_reg(REG_SIN_PITCH, 32'(0));
        write_reg(REG_COS_YAW, 32'(16384));
        write_reg(REG_SIN_YAW, 32'(0));
        write_reg(REG_CAM_X, 32'(0));
        write_reg(REG_CAM_Y, 32'(0));
        write_reg(REG_CAM_Z, 32'(0));
        write_reg(REG_FOCAL, (k == 0) ? 32'h0080_0080 : 32'h0000_0000);
      end
      1: begin
        write_reg(REG_COS_PITCH, 32'hFFFF_C000);
        write_reg(REG_SIN_PITCH, 32'(16384));
        write_reg(REG_COS_YAW, 32'hFFFF_C000);
        write_reg(REG_SIN_YAW, 32'hFFFF_C000);
        write_reg(REG_CAM_X, 32'h8000_0000);
        write_reg(REG_CAM_Y, 32'h7FFF_FFFF);
        write_reg(REG_CAM_Z, 32'h8000_0000);
        write_reg(REG_FOCAL, 32'hFFFF_FFFF);
      end
      default: begin
        pitch = ($itor($urandom_range(0, 1000)) - 500.0) / 1000.0;
        yaw = ($itor($urandom_range(0, 1000)) - 500.0) / 1000.0;
        write_reg(REG_COS_PITCH, 32'($signed(q14($cos(pitch)))));
        write_reg(REG_SIN_PITCH, 32'($signed(q14($sin(pitch)))));
        write_reg(REG_COS_YAW, 32'($signed(q14($cos(yaw)))));
        write_reg(REG_SIN_YAW, 32'($signed(q14($sin(yaw)))));
        write_reg(REG_CAM_X, 32'(longint'($urandom_range(0, 32'(8*Q))) - 4*Q));
        write_reg(REG_CAM_Y, 32'(longint'($urandom_range(0, 32'(8*Q))) - 4*Q));
        write_reg(REG_CAM_Z, 32'(longint'($urandom_range(0, 32'(8*Q))) - 4*Q));
        write_reg(REG_FOCAL, {16'($urandom_range(16, 512)), 16'($urandom_range(16, 512))});
      end
    endcase
  endtask

  // Random item: mostly points in front of the camera and queries near the
  // last drawn point, with some raw noise mixed in.
  function automatic cmd_t random_item();
    cmd_t   c;
    longint z, x, y;
    int     pick;
    c = cmd_t'(CMD_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(0, 399);
    if (pick == 0 && clears < 4) begin
      c.mode = MODE_CLEAR;
    end else if (pick < 240) begin
      z = longint'($urandom_range(1, 300)) * Q + longint'($urandom_range(0, 32'(Q - 1)));
      x = longint'($urandom_range(0, 32'(2 * z))) - z;
      y = longint'($urandom_range(0, 32'(2 * z))) - z;
      c.mode = MODE_PROJECT;
      c.point_x = x[31:0];
      c.point_y = z[31:0];
      c.point_z = y[31:0];
    end else if (pick < 280) begin
      c.mode = MODE_PROJECT;
    end else if (pick < 350) begin
      c.mode = MODE_PICK;
      if (pick < 330) begin
        c.query_x = 8'(last_col + $urandom_range(0, 6) - 3);
        c.query_y = 8'(last_row + $urandom_range(0, 6) - 3);
      end
    end else begin
      c.mode = (pick == 1) ? MODE_PICK : MODE_READ;
      if (pick < 390) begin
        c.query_x = 8'(last_col + $urandom_range(0, 4) - 2);
        c.query_y = 8'(last_row + $urandom_range(0, 4) - 2);
      end
    end
    return c;
  endfunction

  initial begin
    res_t none;
    none = '0;
    cpitch = 16384; spitch = 0; cyaw = 16384; syaw = 0;
    camx = 0; camy = 0; camz = 0;
    focal = 32'h0080_0080;
    wipe_stores();

    // Directed items, all under the reset configuration.
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 8'd0, 8'd0, 16'd0, 32'd0});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 255, 255), 1, none);
    add(mk(MODE_PROJECT, 0, Q, 0, 32'hDEADBEEF, 16'h1234, 0, 0, 0), 1,
        '{1'b1, 8'd128, 8'd128, 16'd0, 32'd0});
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 128, 128), 1,
        '{1'b1, 8'd0, 8'd0, 16'd0, 32'hDEADBEEF});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 130, 130), 1, '{1'b1, 8'd0, 8'd0, 16'h1234, 32'd0});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 131, 128), 1, none);
    // Behind the camera and exactly at its depth.
    add(mk(MODE_PROJECT, 0, -Q, 0, 32'h1, 16'h1, 0, 0, 0), 1, none);
    add(mk(MODE_PROJECT, 0, 0, 0, 32'h1, 16'h1, 0, 0, 0), 1, none);
    // Marked point at the top-left corner, marker clipped.
    add(mk(MODE_PROJECT, -Q, Q, Q, 32'hFFFFFFFF, 16'hFFFF, 1, 0, 0), 1,
        '{1'b1, 8'd0, 8'd0, 16'd0, 32'd0});
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 8'd0, 8'd0, 16'd0, MARK_COLOR});
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 2, 2), 1, '{1'b1, 8'd0, 8'd0, 16'd0, MARK_COLOR});
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 3, 0), 1, '{1'b1, 8'd0, 8'd0, 16'd0, 32'd0});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 8'd0, 8'd0, 16'hFFFF, 32'd0});
    // Left of the frame.
    add(mk(MODE_PROJECT, -2 * Q, Q, 0, 32'h5, 16'h5, 1, 0, 0), 1, none);
    // Marked point at the bottom-right corner.
    add(mk(MODE_PROJECT, 255 * Q, 256 * Q, -255 * Q, 32'h0, 16'h0001, 1, 0, 0), 1,
        '{1'b1, 8'd255, 8'd255, 16'd0, 32'd0});
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 255, 255), 1,
        '{1'b1, 8'd0, 8'd0, 16'd0, MARK_COLOR});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 254, 253), 1, '{1'b1, 8'd0, 8'd0, 16'h0001, 32'd0});
    // Coordinate extremes.
    add(mk(MODE_PROJECT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hA5A5A5A5,
           16'h5A5A, 1, 8'hFF, 8'hFF), 0, none);
    add(mk(MODE_PROJECT, -longint'(32'h80000000), 32'h7FFFFFFF, -longint'(32'h80000000),
           32'h5A5A5A5A, 16'hA5A5, 0, 0, 0), 0, none);
    add(mk(MODE_PROJECT, 0, 1, 0, 32'h0, 16'h0, 0, 0, 0), 0, none);
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 128, 128), 0, none);
    add(mk(MODE_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
    add(mk(MODE_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1, '{1'b1, 8'd0, 8'd0, 16'd0, 32'd0});
    add(mk(MODE_PICK, 0, 0, 0, 0, 0, 0, 128, 128), 1, none);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed[i]) issue(directed[i].c, directed[i].typed, directed[i].r);

    // Random phases, each under its own register setting.
    for (int k = 0; k < PHASES; k++) begin
      wait_quiet();
      set_phase(k);
      idling = (k != PHASES - 1);
      for (int n = 0; n < PER_PHASE; n++) issue(random_item(), 0, none);
    end

    start <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d items: %0d points drawn, %0d picks found, %0d reads, %0d clears,",
             items, drawn, picks_found, reads, clears);
    $display("over %0d register settings including extreme angles, offsets and focals.",
             PHASES);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> point_projector_with_picking_top.f
sv/ppp_pkg.sv
sv/ppp_div.sv
sv/ppp_geom.sv
sv/point_projector_with_picking_top.sv
verif/point_projector_with_picking_top_test.sv
